@@ src/pdca_pkg.sv @@
// shared types, constants and lookup for the drive command arbiter
package pdca_pkg;

	localparam int PRIO_W   = 10;
	localparam int NUM_PRIO = 8;
	localparam int IDX_W    = 3;

	// item kinds
	localparam logic FUNC_DRIVE = 1'b0;
	localparam logic FUNC_TICK  = 1'b1;

	// steering report kinds
	localparam logic [1:0] KIND_ANGLE  = 2'd0;
	localparam logic [1:0] KIND_RADIUS = 2'd1;
	localparam logic [1:0] KIND_BOTH   = 2'd2;

	// register indexes
	localparam logic [IDX_W-1:0] REG_LANE      = 3'd0;
	localparam logic [IDX_W-1:0] REG_COLLISION = 3'd1;
	localparam logic [IDX_W-1:0] REG_PASSING   = 3'd2;
	localparam logic [IDX_W-1:0] REG_TURN      = 3'd3;
	localparam logic [IDX_W-1:0] REG_CROSS     = 3'd4;
	localparam logic [IDX_W-1:0] REG_PARALLEL  = 3'd5;
	localparam logic [IDX_W-1:0] REG_PULL_OUT  = 3'd6;
	localparam logic [IDX_W-1:0] REG_IDLE      = 3'd7;

	// source module numbers
	localparam logic [3:0] SRC_LANE      = 4'd0;
	localparam logic [3:0] SRC_PARALLEL  = 4'd1;
	localparam logic [3:0] SRC_CROSS     = 4'd2;
	localparam logic [3:0] SRC_TURN      = 4'd3;
	localparam logic [3:0] SRC_IDLE      = 4'd4;
	localparam logic [3:0] SRC_PULL_OUT  = 4'd5;
	localparam logic [3:0] SRC_COLLISION = 4'd6;
	localparam logic [3:0] SRC_PASSING   = 4'd7;

	localparam logic [15:0] ANGLE_DEFAULT = 16'h5A00;
	localparam logic [7:0]  INCREMENT_GAP = 8'd2;
	localparam logic [7:0]  TICKS_RESET   = 8'd10;
	localparam logic [7:0]  TICKS_MAX     = 8'd255;
	localparam logic [5:0]  LIGHT_TURN    = 6'b000110;
	localparam logic [5:0]  LIGHT_SAFE    = 6'b011000;

	typedef logic [PRIO_W-1:0] prio_t;
	typedef prio_t prio_arr_t [NUM_PRIO];

	typedef struct packed {
		logic              func;
		logic [3:0]        source_module;
		logic              take_speed;
		logic              take_steering;
		logic signed [15:0] speed_in;
		logic signed [15:0] radius_in;
		logic signed [15:0] angle_in;
		logic [5:0]        lights_in;
		logic              error_in;
		logic              done_in;
		logic [3:0]        reset_req_in;
	} item_t;

	typedef struct packed {
		logic signed [15:0] speed_out;
		logic signed [15:0] steer_value;
		logic [1:0]        steer_kind;
		logic [5:0]        lights_out;
		logic              error_pulse;
		logic              increment_pulse;
		logic              reset_valid;
		logic [3:0]        reset_target;
	} result_t;

	// reset priority of each register
	function automatic prio_t prio_reset(input logic [IDX_W-1:0] idx);
		prio_t v;
		unique case (idx)
			REG_LANE:      v = 10'd1;
			REG_COLLISION: v = 10'd2;
			REG_PASSING:   v = 10'd3;
			REG_TURN:      v = 10'd4;
			REG_CROSS:     v = 10'd10;
			REG_PARALLEL:  v = 10'd11;
			REG_PULL_OUT:  v = 10'd12;
			REG_IDLE:      v = 10'd999;
			default:       v = '0;
		endcase
		return v;
	endfunction

	// priority register that belongs to a source module
	function automatic logic [IDX_W-1:0] module_reg(input logic [3:0] src);
		logic [IDX_W-1:0] r;
		unique case (src)
			SRC_LANE:      r = REG_LANE;
			SRC_PARALLEL:  r = REG_PARALLEL;
			SRC_CROSS:     r = REG_CROSS;
			SRC_TURN:      r = REG_TURN;
			SRC_IDLE:      r = REG_IDLE;
			SRC_PULL_OUT:  r = REG_PULL_OUT;
			SRC_COLLISION: r = REG_COLLISION;
			SRC_PASSING:   r = REG_PASSING;
			default:       r = REG_LANE;
		endcase
		return r;
	endfunction

endpackage

@@ src/pdca_core.sv @@
// channel arbitration state and tick result logic
module pdca_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  pdca_pkg::item_t   item,
	input  pdca_pkg::prio_arr_t prio,
	output pdca_pkg::result_t res
);
	import pdca_pkg::*;

	logic [15:0] held_speed_q, held_radius_q, held_angle_q;
	logic [5:0]  held_lights_q;
	logic        held_error_q, held_done_q;
	logic [3:0]  held_reset_target_q;
	prio_t       top_general_q, top_speed_q, top_steering_q;
	logic [7:0]  ticks_q;

	logic        known, claim, drive, tick;
	prio_t       p;
	logic        gen_take, gen_rel, spd_take, spd_rel, str_take, str_rel;
	logic        inc_fire;
	logic [15:0] eff_angle, eff_radius, eff_speed;
	logic [5:0]  eff_lights;
	logic [7:0]  ticks_next;

	// source priority; unknown modules never match a holder
	assign known = (item.source_module[3] == 1'b0);
	assign p     = prio[module_reg(item.source_module)];
	assign claim = item.take_speed | item.take_steering;
	assign drive = go && (item.func == FUNC_DRIVE);
	assign tick  = go && (item.func == FUNC_TICK);

	// claim and release decisions per channel
	assign gen_take = drive && known && claim && (p >= top_general_q);
	assign gen_rel  = drive && known && !claim && (p == top_general_q);
	assign spd_take = drive && known && item.take_speed && (p >= top_speed_q);
	assign spd_rel  = drive && known && !item.take_speed && (p == top_speed_q);
	assign str_take = drive && known && item.take_steering && (p >= top_steering_q);
	assign str_rel  = drive && known && !item.take_steering && (p == top_steering_q);

	// safe stop overrides on error
	assign eff_angle  = held_error_q ? ANGLE_DEFAULT : held_angle_q;
	assign eff_radius = held_error_q ? 16'd0 : held_radius_q;
	assign eff_speed  = held_error_q ? 16'd0 : held_speed_q;
	assign eff_lights = held_error_q ? (held_lights_q | LIGHT_SAFE) : held_lights_q;

	// rate limited increment counter
	assign inc_fire   = held_done_q && (ticks_q > INCREMENT_GAP);
	always_comb begin
		if (inc_fire) begin
			ticks_next = 8'd1;
		end else if (ticks_q < TICKS_MAX) begin
			ticks_next = ticks_q + 8'd1;
		end else begin
			ticks_next = ticks_q;
		end
	end

	// result of a tick
	always_comb begin
		res.speed_out       = eff_speed;
		res.lights_out      = eff_lights;
		res.error_pulse     = held_error_q;
		res.increment_pulse = inc_fire;
		res.reset_valid     = (held_reset_target_q != 4'd0);
		res.reset_target    = held_reset_target_q;
		if (eff_radius == 16'd0 && eff_angle != 16'd0) begin
			res.steer_kind  = KIND_ANGLE;
			res.steer_value = eff_angle;
		end else if (eff_angle == 16'd0 && eff_radius != 16'd0) begin
			res.steer_kind  = KIND_RADIUS;
			res.steer_value = eff_radius;
		end else if (eff_angle == 16'd0) begin
			res.steer_kind  = KIND_ANGLE;
			res.steer_value = ANGLE_DEFAULT;
		end else begin
			// both set: no steering and no turn signals
			res.steer_kind  = KIND_BOTH;
			res.steer_value = 16'd0;
			res.lights_out  = eff_lights & ~LIGHT_TURN;
		end
	end

	// held values and holder priorities
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_speed_q        <= '0;
			held_radius_q       <= '0;
			held_angle_q        <= ANGLE_DEFAULT;
			held_lights_q       <= '0;
			held_error_q        <= 1'b0;
			held_done_q         <= 1'b0;
			held_reset_target_q <= '0;
			top_general_q       <= '0;
			top_speed_q         <= '0;
			top_steering_q      <= '0;
			ticks_q             <= TICKS_RESET;
		end else if (tick) begin
			held_speed_q  <= eff_speed;
			held_radius_q <= eff_radius;
			held_angle_q  <= eff_angle;
			held_lights_q <= eff_lights;
			ticks_q       <= ticks_next;
		end else begin
			if (gen_take) begin
				held_lights_q       <= item.lights_in;
				held_error_q        <= item.error_in;
				held_done_q         <= item.done_in;
				held_reset_target_q <= item.reset_req_in;
				top_general_q       <= p;
			end else if (gen_rel) begin
				top_general_q <= '0;
			end
			if (spd_take) begin
				held_speed_q <= item.speed_in;
				top_speed_q  <= p;
			end else if (spd_rel) begin
				top_speed_q <= '0;
			end
			if (str_take) begin
				held_radius_q  <= item.radius_in;
				held_angle_q   <= item.angle_in;
				top_steering_q <= p;
			end else if (str_rel) begin
				top_steering_q <= '0;
			end
		end
	end

endmodule

@@ src/pdca_out.sv @@
// result register towards the output channel
module pdca_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  pdca_pkg::result_t res,
	input  logic              out_ready,
	output logic              out_valid,
	output logic              free,
	output pdca_pkg::result_t held
);
	import pdca_pkg::*;

	logic    valid_q;
	result_t res_q;

	// slot can take a new item when empty or being drained
	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign held      = res_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

@@ src/priority_drive_command_arbiter.sv @@
// Drive command arbiter: a tick item is held in the input register, its result in the
// result register. Throughput one item per cycle: input register, one pass of compare
// and select logic, result register; a tick stalls only while the result slot is full
// and not being drained. Reset is asynchronous, active low: priorities return to their
// defaults, channels are released, the held angle is 90 degrees and the increment counter is 10.
module priority_drive_command_arbiter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              func,
	input  logic [3:0]        source_module,
	input  logic              take_speed,
	input  logic              take_steering,
	input  logic signed [15:0] speed_in,
	input  logic signed [15:0] radius_in,
	input  logic signed [15:0] angle_in,
	input  logic [5:0]        lights_in,
	input  logic              error_in,
	input  logic              done_in,
	input  logic [3:0]        reset_req_in,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [15:0] speed_out,
	output logic signed [15:0] steer_value,
	output logic [1:0]        steer_kind,
	output logic [5:0]        lights_out,
	output logic              error_pulse,
	output logic              increment_pulse,
	output logic              reset_valid,
	output logic [3:0]        reset_target,
	input  logic              cfg_we,
	input  logic [pdca_pkg::IDX_W-1:0]  cfg_index,
	input  logic [pdca_pkg::PRIO_W-1:0] cfg_data
);
	import pdca_pkg::*;

	prio_arr_t prio_q;
	item_t     item_s1;
	logic      valid_s1;
	logic      adv, go, free;
	result_t   res, held;

	// priority registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PRIO; i++) begin
				prio_q[i] <= prio_reset(IDX_W'(i));
			end
		end else if (cfg_we) begin
			prio_q[cfg_index] <= cfg_data;
		end
	end

	// input stage moves on unless a tick waits for a full result slot
	assign adv      = !valid_s1 || (item_s1.func == FUNC_DRIVE) || free;
	assign go       = valid_s1 && adv;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			item_s1.func          <= func;
			item_s1.source_module <= source_module;
			item_s1.take_speed    <= take_speed;
			item_s1.take_steering <= take_steering;
			item_s1.speed_in      <= speed_in;
			item_s1.radius_in     <= radius_in;
			item_s1.angle_in      <= angle_in;
			item_s1.lights_in     <= lights_in;
			item_s1.error_in      <= error_in;
			item_s1.done_in       <= done_in;
			item_s1.reset_req_in  <= reset_req_in;
		end
	end

	// arbitration state and tick evaluation
	pdca_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.item   (item_s1),
		.prio   (prio_q),
		.res    (res)
	);

	// result register
	pdca_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (go && (item_s1.func == FUNC_TICK)),
		.res       (res),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.free      (free),
		.held      (held)
	);

	assign speed_out       = held.speed_out;
	assign steer_value     = held.steer_value;
	assign steer_kind      = held.steer_kind;
	assign lights_out      = held.lights_out;
	assign error_pulse     = held.error_pulse;
	assign increment_pulse = held.increment_pulse;
	assign reset_valid     = held.reset_valid;
	assign reset_target    = held.reset_target;

endmodule

@@ sim/priority_drive_command_arbiter_tb.sv @@
// self-checking testbench for the priority drive command arbiter
`timescale 1ns / 100ps

module priority_drive_command_arbiter_tb;
	import pdca_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 80;
	localparam int PHASE_ITEMS  = 170;
	localparam int SETTLE       = 4;

	logic                 clk;
	logic                 arst_n        = 1'b0;
	logic                 in_valid      = 1'b0;
	logic                 in_ready;
	logic                 func          = FUNC_DRIVE;
	logic [3:0]           source_module = '0;
	logic                 take_speed    = 1'b0;
	logic                 take_steering = 1'b0;
	logic signed [15:0]   speed_in      = '0;
	logic signed [15:0]   radius_in     = '0;
	logic signed [15:0]   angle_in      = '0;
	logic [5:0]           lights_in     = '0;
	logic                 error_in      = 1'b0;
	logic                 done_in       = 1'b0;
	logic [3:0]           reset_req_in  = '0;
	logic                 out_valid;
	logic                 out_ready     = 1'b0;
	logic signed [15:0]   speed_out;
	logic signed [15:0]   steer_value;
	logic [1:0]           steer_kind;
	logic [5:0]           lights_out;
	logic                 error_pulse;
	logic                 increment_pulse;
	logic                 reset_valid;
	logic [3:0]           reset_target;
	logic                 cfg_we        = 1'b0;
	logic [IDX_W-1:0]     cfg_index     = '0;
	logic [PRIO_W-1:0]    cfg_data      = '0;

	priority_drive_command_arbiter dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.source_module  (source_module),
		.take_speed     (take_speed),
		.take_steering  (take_steering),
		.speed_in       (speed_in),
		.radius_in      (radius_in),
		.angle_in       (angle_in),
		.lights_in      (lights_in),
		.error_in       (error_in),
		.done_in        (done_in),
		.reset_req_in   (reset_req_in),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.speed_out      (speed_out),
		.steer_value    (steer_value),
		.steer_kind     (steer_kind),
		.lights_out     (lights_out),
		.error_pulse    (error_pulse),
		.increment_pulse(increment_pulse),
		.reset_valid    (reset_valid),
		.reset_target   (reset_target),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// shadow of the arbiter state
	prio_t              prio_cfg [NUM_PRIO];
	logic signed [15:0] held_speed;
	logic signed [15:0] held_radius;
	logic signed [15:0] held_angle;
	logic [5:0]         held_lights;
	logic               held_error;
	logic               held_done;
	logic [3:0]         held_reset_target;
	int                 top_general;
	int                 top_speed;
	int                 top_steering;
	logic [7:0]         held_ticks;

	item_t   cmd_queue [$];
	result_t expected_reports [$];
	item_t   cur_cmd;
	bit      in_taken;
	bit      steady;
	bit      hold_req;
	int      hold_left;
	int      error_count;
	int unsigned cycle_count;
	logic [3:0] last_claimer;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// priority of a source module, unknown modules rank below every holder
	function automatic int source_prio(input logic [3:0] src);
		case (src)
			SRC_LANE:      return int'(prio_cfg[REG_LANE]);
			SRC_PARALLEL:  return int'(prio_cfg[REG_PARALLEL]);
			SRC_CROSS:     return int'(prio_cfg[REG_CROSS]);
			SRC_TURN:      return int'(prio_cfg[REG_TURN]);
			SRC_IDLE:      return int'(prio_cfg[REG_IDLE]);
			SRC_PULL_OUT:  return int'(prio_cfg[REG_PULL_OUT]);
			SRC_COLLISION: return int'(prio_cfg[REG_COLLISION]);
			SRC_PASSING:   return int'(prio_cfg[REG_PASSING]);
			default:       return -1;
		endcase
	endfunction

	// apply one accepted item to the shadow state, queue the report of a tick
	task automatic arbitrate(input item_t c);
		int      p;
		logic    claim;
		result_t r;
		if (c.func == FUNC_DRIVE) begin
			p     = source_prio(c.source_module);
			claim = c.take_speed || c.take_steering;
			// general channel: lights, error, done, reset request
			if (claim && p >= top_general) begin
				held_lights       = c.lights_in;
				held_error        = c.error_in;
				held_done         = c.done_in;
				held_reset_target = c.reset_req_in;
				top_general       = p;
			end else if (!claim && p == top_general) begin
				top_general = 0;
			end
			// speed channel
			if (c.take_speed && p >= top_speed) begin
				held_speed = c.speed_in;
				top_speed  = p;
			end else if (!c.take_speed && p == top_speed) begin
				top_speed = 0;
			end
			// steering channel
			if (c.take_steering && p >= top_steering) begin
				held_radius  = c.radius_in;
				held_angle   = c.angle_in;
				top_steering = p;
			end else if (!c.take_steering && p == top_steering) begin
				top_steering = 0;
			end
		end else begin
			r.reset_valid     = (held_reset_target != 0);
			r.reset_target    = held_reset_target;
			r.error_pulse     = 1'b0;
			r.increment_pulse = 1'b0;
			// safe stop while an error is held
			if (held_error) begin
				held_angle    = ANGLE_DEFAULT;
				held_radius   = '0;
				held_speed    = '0;
				held_lights   = held_lights | LIGHT_SAFE;
				r.error_pulse = 1'b1;
			end
			// rate-limited maneuver increment
			if (held_done && held_ticks > INCREMENT_GAP) begin
				r.increment_pulse = 1'b1;
				held_ticks        = '0;
			end
			if (held_ticks < TICKS_MAX)
				held_ticks = held_ticks + 8'd1;
			r.speed_out  = held_speed;
			r.lights_out = held_lights;
			if (held_radius == 0 && held_angle != 0) begin
				r.steer_kind  = KIND_ANGLE;
				r.steer_value = held_angle;
			end else if (held_angle == 0 && held_radius != 0) begin
				r.steer_kind  = KIND_RADIUS;
				r.steer_value = held_radius;
			end else if (held_angle == 0 && held_radius == 0) begin
				r.steer_kind  = KIND_ANGLE;
				r.steer_value = ANGLE_DEFAULT;
			end else begin
				r.steer_kind  = KIND_BOTH;
				r.steer_value = '0;
				r.lights_out  = held_lights & ~LIGHT_TURN;
			end
			expected_reports.push_back(r);
		end
	endtask

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("mismatch on %s: got %0d, expected %0d (cycle %0d)",
			what, got, want, cycle_count);
		error_count++;
	endtask

	// tick with random don't-care fields
	function automatic item_t tick_cmd();
		item_t c;
		c.func          = FUNC_TICK;
		c.source_module = 4'($urandom);
		c.take_speed    = 1'($urandom);
		c.take_steering = 1'($urandom);
		c.speed_in      = 16'($urandom);
		c.radius_in     = 16'($urandom);
		c.angle_in      = 16'($urandom);
		c.lights_in     = 6'($urandom);
		c.error_in      = 1'($urandom);
		c.done_in       = 1'($urandom);
		c.reset_req_in  = 4'($urandom);
		return c;
	endfunction

	function automatic item_t drive_cmd(input logic [3:0] src, input logic tsp,
			input logic tst, input logic signed [15:0] spd,
			input logic signed [15:0] rad, input logic signed [15:0] ang,
			input logic [5:0] lights, input logic err, input logic done,
			input logic [3:0] rst);
		item_t c;
		c = '{FUNC_DRIVE, src, tsp, tst, spd, rad, ang, lights, err, done, rst};
		return c;
	endfunction

	// Q8.8 value biased towards zero and the extremes
	function automatic logic signed [15:0] wide_value();
		int r;
		r = $urandom_range(99);
		if (r < 25)
			return '0;
		if (r < 32)
			return 16'sh8000;
		if (r < 39)
			return 16'sh7FFF;
		return 16'($urandom);
	endfunction

	// mostly claims and releases by known modules, some noise
	function automatic item_t random_cmd();
		item_t c;
		int    pick;
		c    = tick_cmd();
		pick = $urandom_range(99);
		if (pick < 30)
			return c;
		c.func = FUNC_DRIVE;
		if (pick < 38) begin
			c.source_module = 4'($urandom_range(15));
			{c.take_speed, c.take_steering} = 2'($urandom_range(3));
		end else if (pick < 52) begin
			// release by the module that claimed last
			c.source_module = last_claimer;
			c.take_speed    = 1'b0;
			c.take_steering = 1'b0;
		end else begin
			c.source_module = 4'($urandom_range(7));
			{c.take_speed, c.take_steering} = 2'($urandom_range(1, 3));
		end
		c.speed_in     = wide_value();
		c.radius_in    = wide_value();
		c.angle_in     = wide_value();
		c.error_in     = ($urandom_range(9) == 0);
		c.done_in      = ($urandom_range(2) == 0);
		c.reset_req_in = ($urandom_range(4) == 0) ? 4'($urandom) : 4'd0;
		if (c.take_speed || c.take_steering)
			last_claimer = c.source_module;
		return c;
	endfunction

	task automatic write_prio(input int idx, input prio_t value);
		@(negedge clk);
		cfg_we        <= 1'b1;
		cfg_index     <= IDX_W'(idx);
		cfg_data      <= value;
		prio_cfg[idx]  = value;
	endtask

	task automatic end_config();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait for queue, handshake and expectations to drain, then let the pipe settle
	task automatic wait_idle();
		while (cmd_queue.size() != 0 || in_valid || expected_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic run_random(input int n);
		for (int i = 0; i < n; i++)
			cmd_queue.push_back(random_cmd());
	endtask

	// input driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			in_taken = 1'b0;
			if (cmd_queue.size() != 0 && (steady || $urandom_range(99) >= 20)) begin
				cur_cmd        = cmd_queue.pop_front();
				in_valid      <= 1'b1;
				func          <= cur_cmd.func;
				source_module <= cur_cmd.source_module;
				take_speed    <= cur_cmd.take_speed;
				take_steering <= cur_cmd.take_steering;
				speed_in      <= cur_cmd.speed_in;
				radius_in     <= cur_cmd.radius_in;
				angle_in      <= cur_cmd.angle_in;
				lights_in     <= cur_cmd.lights_in;
				error_in      <= cur_cmd.error_in;
				done_in       <= cur_cmd.done_in;
				reset_req_in  <= cur_cmd.reset_req_in;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver with random stalls and one long hold-off
	always @(negedge clk) begin
		if (hold_left == 0 && hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (steady) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= 20);
		end
	end

	// monitor: check results, track accepted items, watchdog
	always @(posedge clk) begin
		result_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL priority_drive_command_arbiter");
			$finish;
		end
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_reports.size() == 0) begin
					flag_mismatch("unexpected result", 1, 0);
				end else begin
					want = expected_reports.pop_front();
					if (speed_out !== want.speed_out)
						flag_mismatch("speed_out", speed_out, want.speed_out);
					if (steer_value !== want.steer_value)
						flag_mismatch("steer_value", steer_value, want.steer_value);
					if (steer_kind !== want.steer_kind)
						flag_mismatch("steer_kind", steer_kind, want.steer_kind);
					if (lights_out !== want.lights_out)
						flag_mismatch("lights_out", lights_out, want.lights_out);
					if (error_pulse !== want.error_pulse)
						flag_mismatch("error_pulse", error_pulse, want.error_pulse);
					if (increment_pulse !== want.increment_pulse)
						flag_mismatch("increment_pulse", increment_pulse,
							want.increment_pulse);
					if (reset_valid !== want.reset_valid)
						flag_mismatch("reset_valid", reset_valid, want.reset_valid);
					if (reset_target !== want.reset_target)
						flag_mismatch("reset_target", reset_target, want.reset_target);
				end
			end
			if (in_valid && in_ready) begin
				arbitrate(cur_cmd);
				in_taken = 1'b1;
			end
		end
	end

	// stimulus sequence
	initial begin
		// shadow state after reset
		prio_cfg[REG_LANE]      = 10'd1;
		prio_cfg[REG_COLLISION] = 10'd2;
		prio_cfg[REG_PASSING]   = 10'd3;
		prio_cfg[REG_TURN]      = 10'd4;
		prio_cfg[REG_CROSS]     = 10'd10;
		prio_cfg[REG_PARALLEL]  = 10'd11;
		prio_cfg[REG_PULL_OUT]  = 10'd12;
		prio_cfg[REG_IDLE]      = 10'd999;
		held_speed        = '0;
		held_radius       = '0;
		held_angle        = ANGLE_DEFAULT;
		held_lights       = '0;
		held_error        = 1'b0;
		held_done         = 1'b0;
		held_reset_target = '0;
		top_general       = 0;
		top_speed         = 0;
		top_steering      = 0;
		held_ticks        = TICKS_RESET;
		last_claimer      = SRC_LANE;
		in_taken          = 1'b0;
		steady            = 1'b0;
		hold_req          = 1'b0;
		hold_left         = 0;
		error_count       = 0;
		cycle_count       = 0;

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// directed part at reset priorities
		cmd_queue.push_back(tick_cmd());
		// angle only, speed at the top extreme
		cmd_queue.push_back(drive_cmd(SRC_LANE, 1'b1, 1'b1, 16'sh7FFF, 16'sh0000,
			16'sh1E00, 6'h01, 1'b0, 1'b0, 4'd0));
		cmd_queue.push_back(tick_cmd());
		// radius only at the bottom extreme, all lights, reset request
		cmd_queue.push_back(drive_cmd(SRC_TURN, 1'b0, 1'b1, 16'sh0100, 16'sh8000,
			16'sh0000, 6'h3F, 1'b0, 1'b0, 4'hF));
		cmd_queue.push_back(tick_cmd());
		// lower priority takes speed only where the channel is free enough
		cmd_queue.push_back(drive_cmd(SRC_LANE, 1'b1, 1'b0, 16'sh8000, 16'sh0000,
			16'sh0000, 6'h00, 1'b1, 1'b1, 4'd3));
		// lower priority than the steering holder: takes speed only, steering ignored
		cmd_queue.push_back(drive_cmd(SRC_COLLISION, 1'b1, 1'b1, 16'sh0000, 16'sh0100,
			16'sh0200, 6'h3F, 1'b0, 1'b0, 4'd0));
		cmd_queue.push_back(tick_cmd());
		// angle and radius both set: inconsistent steering, turn lights masked
		cmd_queue.push_back(drive_cmd(SRC_IDLE, 1'b1, 1'b1, 16'sh0040, 16'shFF00,
			16'sh0200, 6'h3F, 1'b0, 1'b0, 4'd0));
		cmd_queue.push_back(tick_cmd());
		// unknown module claims everything and is ignored
		cmd_queue.push_back(drive_cmd(4'd15, 1'b1, 1'b1, 16'sh1234, 16'sh0000,
			16'sh0000, 6'h00, 1'b1, 1'b1, 4'd5));
		cmd_queue.push_back(tick_cmd());
		// release by the holder, then neither angle nor radius set
		cmd_queue.push_back(drive_cmd(SRC_IDLE, 1'b0, 1'b0, 16'sh0000, 16'sh0000,
			16'sh0000, 6'h00, 1'b0, 1'b0, 4'd0));
		cmd_queue.push_back(drive_cmd(SRC_IDLE, 1'b0, 1'b1, 16'sh0000, 16'sh0000,
			16'sh0000, 6'h00, 1'b0, 1'b0, 4'd0));
		cmd_queue.push_back(tick_cmd());
		cmd_queue.push_back(drive_cmd(SRC_IDLE, 1'b0, 1'b0, 16'sh0000, 16'sh0000,
			16'sh0000, 6'h00, 1'b0, 1'b0, 4'd0));
		// error forces a safe stop, done raises rate-limited increments
		cmd_queue.push_back(drive_cmd(SRC_CROSS, 1'b1, 1'b0, 16'sh0300, 16'sh0000,
			16'sh0000, 6'h21, 1'b1, 1'b1, 4'd0));
		repeat (4) cmd_queue.push_back(tick_cmd());
		// unknown module release has no effect
		cmd_queue.push_back(drive_cmd(4'd9, 1'b0, 1'b0, 16'sh0000, 16'sh0000,
			16'sh0000, 6'h00, 1'b0, 1'b0, 4'd0));
		cmd_queue.push_back(drive_cmd(SRC_PULL_OUT, 1'b1, 1'b1, 16'sh7FFF, 16'sh0000,
			16'sh8000, 6'h2A, 1'b0, 1'b1, 4'd1));
		cmd_queue.push_back(tick_cmd());
		wait_idle();

		// alternating lowest and highest priorities
		for (int i = 0; i < NUM_PRIO; i++)
			write_prio(i, i[0] ? 10'd1023 : 10'd0);
		end_config();
		run_random(PHASE_ITEMS);
		wait_idle();

		// every module at the top priority, no idling, one long receiver hold-off
		for (int i = 0; i < NUM_PRIO; i++)
			write_prio(i, 10'd1023);
		end_config();
		steady   = 1'b1;
		run_random(PHASE_ITEMS);
		hold_req = 1'b1;
		wait_idle();
		steady   = 1'b0;

		// random priorities
		for (int i = 0; i < NUM_PRIO; i++)
			write_prio(i, prio_t'($urandom_range(1023)));
		end_config();
		run_random(PHASE_ITEMS);
		wait_idle();

		// every module at the bottom priority
		for (int i = 0; i < NUM_PRIO; i++)
			write_prio(i, 10'd0);
		end_config();
		run_random(PHASE_ITEMS);
		wait_idle();

		// small priorities, many ties
		for (int i = 0; i < NUM_PRIO; i++)
			write_prio(i, prio_t'($urandom_range(3)));
		end_config();
		run_random(PHASE_ITEMS);
		wait_idle();

		repeat (8) @(posedge clk);
		if (error_count == 0) begin
			$display("PASS priority_drive_command_arbiter");
		end else begin
			$display("FAIL priority_drive_command_arbiter");
		end
		$finish;
	end

endmodule
